// ===== src/mmh_pkg.sv =====
package mmh_pkg;

  // Message length counter width; lengths at or past 2^LEN_BITS set too_long
  localparam int LEN_BITS = 31;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [4:0] FULL_BYTES = 5'd16;
  localparam logic [4:0] WORD_BYTES = 5'd8;

  // Mixing and finalizer constants
  localparam logic [63:0] MIX_C1  = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] FIN_M1  = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_M2  = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] ADD_ONE = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] ADD_TWO = 64'h0000_0000_3849_5ab5;

  // One classified block as it waits in the queue
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  n;      // bytes added to the length
    logic        full;   // block mix, otherwise tail mix
    logic        last;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_K1A,
    B_K1B,
    B_K2A,
    B_K2B,
    B_LANE1,
    B_LANE2,
    B_FIN0,
    B_FIN1,
    B_FA1,
    B_FA2,
    B_FB1,
    B_FB2,
    B_OUT
  } back_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] xshift33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

  // Keep the low n bytes of a word (all of them for n of 8 or more)
  function automatic logic [63:0] byte_mask(input logic [4:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (5'(i) < n) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== src/mmh_front.sv =====
module mmh_front
  import mmh_pkg::*;
(
  input  logic        in_valid,
  input  logic        q_ready,
  input  logic [63:0] data_low,
  input  logic [63:0] data_high,
  input  logic [4:0]  byte_count,
  input  logic        last,
  output logic        push,
  output item_t       item
);

  logic [4:0] n_sat;
  logic [4:0] n_hi;
  logic       full;

  // Saturate the count and pick block or tail mix
  always_comb begin
    n_sat = (byte_count > FULL_BYTES) ? FULL_BYTES : byte_count;
    n_hi  = (n_sat > WORD_BYTES) ? n_sat - WORD_BYTES : 5'd0;
    full  = !last || (n_sat == FULL_BYTES);
  end

  // Mask bytes past the count; a zero word mixes to zero in the tail
  always_comb begin
    item.lo   = full ? data_low  : (data_low  & byte_mask(n_sat));
    item.hi   = full ? data_high : (data_high & byte_mask(n_hi));
    item.n    = last ? n_sat : FULL_BYTES;
    item.full = full;
    item.last = last;
  end

  assign push = in_valid && q_ready;

endmodule

// ===== src/mmh_queue.sv =====
module mmh_queue
  import mmh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  wr_ready,
  input  logic  pop,
  output logic  rd_valid,
  output item_t rd_item
);

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] cnt;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ready = (cnt != Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_item  = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_item;
  end

endmodule

// ===== src/mmh_back.sv =====
module mmh_back
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [63:0] seed,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash,
  output logic        too_long
);

  back_state_t state, state_next;

  logic [1:0]  ph;
  logic        is_mul;
  logic        mul_done;
  logic        out_load;
  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] mul_res;
  logic [63:0] mix_r;

  logic [63:0] seed_r;
  logic [63:0] lane_one;
  logic [63:0] lane_two;
  logic [LEN_BITS-1:0] bytes_seen;
  logic        overflowed;

  logic [63:0] op;
  logic [63:0] k1;
  logic [63:0] k2;
  logic [63:0] w_hi;
  logic [4:0]  w_n;
  logic        w_full;
  logic        w_last;

  logic [63:0]       l1_mix, l1_blk, l2_mix, l2_blk;
  logic [LEN_BITS:0] bs_sum;
  logic [63:0]       bs_ext, fin_a, fin_b;

  // Sequence one item: key multiplies, lane update, then finalization on last
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    is_mul     = 1'b0;
    mul_c      = MIX_C1;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_K1A;
        end
      end
      B_K1A: begin
        is_mul = 1'b1;
        mul_c  = MIX_C1;
        if (ph == 2'd3) state_next = B_K1B;
      end
      B_K1B: begin
        is_mul = 1'b1;
        mul_c  = MIX_C2;
        if (ph == 2'd3) state_next = B_K2A;
      end
      B_K2A: begin
        is_mul = 1'b1;
        mul_c  = MIX_C2;
        if (ph == 2'd3) state_next = B_K2B;
      end
      B_K2B: begin
        is_mul = 1'b1;
        mul_c  = MIX_C1;
        if (ph == 2'd3) state_next = B_LANE1;
      end
      B_LANE1: begin
        if (w_full)      state_next = B_LANE2;
        else if (w_last) state_next = B_FIN0;
        else             state_next = B_IDLE;
      end
      B_LANE2: state_next = w_last ? B_FIN0 : B_IDLE;
      B_FIN0:  state_next = B_FIN1;
      B_FIN1:  state_next = B_FA1;
      B_FA1: begin
        is_mul = 1'b1;
        mul_c  = FIN_M1;
        if (ph == 2'd3) state_next = B_FA2;
      end
      B_FA2: begin
        is_mul = 1'b1;
        mul_c  = FIN_M2;
        if (ph == 2'd3) state_next = B_FB1;
      end
      B_FB1: begin
        is_mul = 1'b1;
        mul_c  = FIN_M1;
        if (ph == 2'd3) state_next = B_FB2;
      end
      B_FB2: begin
        is_mul = 1'b1;
        mul_c  = FIN_M2;
        if (ph == 2'd3) state_next = B_OUT;
      end
      B_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // Shared 32x32 multiplier: lo*lo, lo*hi, hi*lo, then final add
  assign mul_done = is_mul && (ph == 2'd3);
  assign mul_a    = ph[1] ? op[63:32] : op[31:0];
  assign mul_b    = (ph == 2'd1) ? mul_c[63:32] : mul_c[31:0];
  assign mul_res  = acc + {prod[31:0], 32'b0};
  assign mix_r    = xshift33(mul_res);

  // Lane recurrences, length count and finalizer entry
  always_comb begin
    l1_mix = rotl64(lane_one ^ k1, 27) + lane_two;
    l1_blk = l1_mix + {l1_mix[61:0], 2'b00} + ADD_ONE;
    l2_mix = rotl64(lane_two ^ k2, 31) + lane_one;
    l2_blk = l2_mix + {l2_mix[61:0], 2'b00} + ADD_TWO;
    bs_sum = {1'b0, bytes_seen} + (LEN_BITS + 1)'(w_n);
    bs_ext = 64'(bytes_seen);
    fin_a  = (lane_one ^ bs_ext) + (lane_two ^ bs_ext);
    fin_b  = (lane_two ^ bs_ext) + lane_one;
  end

  // Hash state, seed, phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ph         <= '0;
      seed_r     <= '0;
      lane_one   <= '0;
      lane_two   <= '0;
      bytes_seen <= '0;
      overflowed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      ph <= is_mul ? ph + 2'd1 : 2'd0;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_valid) begin
        seed_r     <= seed;
        lane_one   <= seed;
        lane_two   <= seed;
        bytes_seen <= '0;
        overflowed <= 1'b0;
      end else begin
        case (state)
          B_LANE1: begin
            if (w_full) begin
              lane_one <= l1_blk;
            end else begin
              lane_one <= lane_one ^ k1;
              lane_two <= lane_two ^ k2;
            end
            bytes_seen <= bs_sum[LEN_BITS-1:0];
            overflowed <= overflowed | bs_sum[LEN_BITS];
          end
          B_LANE2: lane_two <= l2_blk;
          B_FIN0:  lane_one <= fin_a;
          B_FIN1:  lane_two <= fin_b;
          B_FA2:   if (mul_done) lane_one <= mix_r;
          B_FB2:   if (mul_done) lane_two <= mix_r;
          B_OUT: begin
            if (out_load) begin
              lane_one   <= seed_r;
              lane_two   <= seed_r;
              bytes_seen <= '0;
              overflowed <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath payload: products, operands, keys, working item, result
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ph == 2'd1)      acc <= prod;
    else if (ph == 2'd2) acc <= mul_res;
    if (q_pop) begin
      op     <= q_item.lo;
      w_hi   <= q_item.hi;
      w_n    <= q_item.n;
      w_full <= q_item.full;
      w_last <= q_item.last;
    end
    if (out_load) begin
      hash     <= lane_one + lane_two;
      too_long <= overflowed;
    end
    case (state)
      B_K1A: if (mul_done) op <= rotl64(mul_res, 31);
      B_K1B: begin
        if (mul_done) begin
          k1 <= mul_res;
          op <= w_hi;
        end
      end
      B_K2A: if (mul_done) op <= rotl64(mul_res, 33);
      B_K2B: if (mul_done) k2 <= mul_res;
      B_FIN1: op <= xshift33(lane_one);
      B_FA1:  if (mul_done) op <= mix_r;
      B_FA2:  if (mul_done) op <= xshift33(lane_two);
      B_FB1:  if (mul_done) op <= mix_r;
      default: ;
    endcase
  end

endmodule

// ===== src/murmur3_x64_128_fold_hash_unit.sv =====
// The back end takes a new item only once it is through with the last one. A
// last item shows its result after its key mixes, lane update (a partial tail
// skips the second lane) and finalizer, when the back end is free.
// The single shared 32x32 multiplier, which builds each 64-bit product in phases
// (8 products per message end), sets the pace; a two-entry queue takes items
// meanwhile.
// Reset: synchronous, clears seed and lanes to zero and empties the queue.
module murmur3_x64_128_fold_hash_unit
  import mmh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_low,
  input  logic [63:0] data_high,
  input  logic [4:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash,
  output logic        too_long
);

  logic  push;
  logic  q_valid;
  logic  q_pop;
  item_t wr_item;
  item_t rd_item;

  // Seed writes are always accepted and registered
  assign cfg_ready = 1'b1;

  mmh_front u_front (
    .in_valid   (in_valid),
    .q_ready    (in_ready),
    .data_low   (data_low),
    .data_high  (data_high),
    .byte_count (byte_count),
    .last       (last),
    .push       (push),
    .item       (wr_item)
  );

  mmh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_item  (wr_item),
    .wr_ready (in_ready),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (rd_item)
  );

  mmh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .seed      (seed),
    .q_valid   (q_valid),
    .q_item    (rd_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash      (hash),
    .too_long  (too_long)
  );

endmodule

// ===== src/mmh_checker.sv =====
module mmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] hash,
  input logic        too_long
);

  logic [3:0] pend;
  logic       last_in;
  logic       res_out;

  assign last_in = in_valid && in_ready && last;
  assign res_out = out_valid && out_ready;

  // Track last items accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (last_in && !res_out) begin
      pend <= pend + 4'd1;
    end else if (res_out && !last_in) begin
      pend <= pend - 4'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash) && $stable(too_long))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pend != 4'd0)
    else $error("result without a pending last item");

  a_bounded_pend: assert property (@(posedge clk) disable iff (rst)
    pend <= 4'd4)
    else $error("more last items in flight than the unit can hold");

endmodule

bind murmur3_x64_128_fold_hash_unit mmh_checker u_mmh_checker (.*);
